// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clk edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check prop on the default clock and reset names
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/hsv_pkg.sv =====
// Types and constants of the HSV to RGB converter
package hsv_pkg;

  localparam int unsigned HueW     = 16;
  localparam int unsigned QW       = 15;
  localparam int unsigned FracW    = 12;
  localparam int unsigned WW       = 27;
  localparam int unsigned ProdW    = 42;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [16:0] HueOfs    = 17'd46080;
  localparam logic [16:0] HueFull1  = 17'd23040;
  localparam logic [16:0] HueFull2  = 17'd46080;
  localparam logic [16:0] HueFull3  = 17'd69120;
  localparam logic [14:0] HueSector = 15'd3840;
  localparam logic [14:0] QOne      = 15'd16384;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } hsv_sector_e;

  typedef struct packed {
    hsv_sector_e       sec;
    logic [FracW-1:0]  fn;
    logic [QW-1:0]     s;
    logic [QW-1:0]     v;
    logic [ByteW-1:0]  bc;
  } hsv_front_t;

  typedef struct packed {
    hsv_sector_e       sec;
    logic [ByteW-1:0]  bc;
    logic [ByteW-1:0]  b0;
    logic [ProdW-1:0]  vw;
  } hsv_mult_t;

endpackage

// ===== hdl/hsv_front.sv =====
// Hue wrap, clamping and sector split (stages 1 and 2)
`include "assert_macros.svh"

module hsv_front
  import hsv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [HueW-1:0]  sat_i,
  input  logic [HueW-1:0]  val_i,
  output logic             vld_o,
  output hsv_front_t       data_o
);

  logic             vld1_q, vld2_q;
  logic [QW-1:0]    hw_d, hw_q, s1_d, s1_q, v1_d, v1_q;
  logic [16:0]      hue_ofs;
  hsv_front_t       st2_d, st2_q;
  logic [QW-1:0]    base;
  logic [FracW-1:0] fr;
  logic [22:0]      vsc;

  function automatic logic [QW-1:0] clamp_unit(input logic [HueW-1:0] q);
    logic [QW-1:0] r;
    if (q[HueW-1]) begin
      r = '0;
    end else if (q[QW-1:0] > QOne) begin
      r = QOne;
    end else begin
      r = q[QW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    hue_ofs = {hue_i[HueW-1], hue_i} + HueOfs;
    if (hue_ofs >= HueFull3) begin
      hw_d = QW'(hue_ofs - HueFull3);
    end else if (hue_ofs >= HueFull2) begin
      hw_d = QW'(hue_ofs - HueFull2);
    end else if (hue_ofs >= HueFull1) begin
      hw_d = QW'(hue_ofs - HueFull1);
    end else begin
      hw_d = QW'(hue_ofs);
    end
    s1_d = clamp_unit(sat_i);
    v1_d = clamp_unit(val_i);
  end

  always_comb begin
    if (hw_q >= 15'd19200) begin
      st2_d.sec = SEC_MR;
      base      = 15'd19200;
    end else if (hw_q >= 15'd15360) begin
      st2_d.sec = SEC_BM;
      base      = 15'd15360;
    end else if (hw_q >= 15'd11520) begin
      st2_d.sec = SEC_CB;
      base      = 15'd11520;
    end else if (hw_q >= 15'd7680) begin
      st2_d.sec = SEC_GC;
      base      = 15'd7680;
    end else if (hw_q >= HueSector) begin
      st2_d.sec = SEC_YG;
      base      = HueSector;
    end else begin
      st2_d.sec = SEC_RY;
      base      = '0;
    end
    fr        = FracW'(hw_q - base);
    st2_d.fn  = st2_d.sec[0] ? FracW'(HueSector) - fr : fr;
    st2_d.s   = s1_q;
    st2_d.v   = v1_q;
    vsc       = ({8'd0, v1_q} << 8) - {8'd0, v1_q} + 23'd8192;
    st2_d.bc  = vsc[21:14];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hw_q  <= hw_d;
      s1_q  <= s1_d;
      v1_q  <= v1_d;
      st2_q <= st2_d;
    end
  end

  assign vld_o  = vld2_q;
  assign data_o = st2_q;

  `ASSERT_STD(a_hue_wrapped, vld1_q |-> (hw_q < 15'd23040), "wrapped hue out of range")
  `ASSERT_STD(a_frac_range, vld2_q |-> (st2_q.fn <= FracW'(HueSector)), "sector fraction too large")

endmodule

// ===== hdl/hsv_mult.sv =====
// Chroma and mix products (stages 3 and 4)
`include "assert_macros.svh"

module hsv_mult
  import hsv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  hsv_front_t  data_i,
  output logic        vld_o,
  output hsv_mult_t   data_o
);

  logic             vld3_q, vld4_q;
  logic [QW-1:0]    u;
  logic [WW-1:0]    w_d, w_q;
  logic [29:0]      vu;
  logic [37:0]      vu_sc;
  logic [QW-1:0]    v3_q;
  hsv_sector_e      sec3_q;
  logic [ByteW-1:0] bc3_q, b0_d, b0_q;
  hsv_mult_t        st4_d, st4_q;

  always_comb begin
    u     = QOne - data_i.s;
    w_d   = WW'(data_i.s) * WW'(data_i.fn) + (WW'(u) << 12) - (WW'(u) << 8);
    vu    = 30'(data_i.v) * 30'(u);
    vu_sc = ({8'd0, vu} << 8) - {8'd0, vu} + 38'd134217728;
    b0_d  = vu_sc[35:28];
  end

  always_comb begin
    st4_d.sec = sec3_q;
    st4_d.bc  = bc3_q;
    st4_d.b0  = b0_q;
    st4_d.vw  = ProdW'(v3_q) * ProdW'(w_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld_i;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q    <= w_d;
      v3_q   <= data_i.v;
      sec3_q <= data_i.sec;
      bc3_q  <= data_i.bc;
      b0_q   <= b0_d;
      st4_q  <= st4_d;
    end
  end

  assign vld_o  = vld4_q;
  assign data_o = st4_q;

  `ASSERT_STD(a_offset_le_max, vld4_q |-> (st4_q.b0 <= st4_q.bc), "offset above max channel")

endmodule

// ===== hdl/hsv_back.sv =====
// Mixed channel scaling, rounding and channel routing (stages 5 and 6)
`include "assert_macros.svh"

module hsv_back
  import hsv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  hsv_mult_t        data_i,
  output logic             vld_o,
  output logic [ByteW-1:0] red_o,
  output logic [ByteW-1:0] green_o,
  output logic [ByteW-1:0] blue_o
);

  logic             vld5_q, vld6_q;
  logic [49:0]      n;
  logic [11:0]      y_d, y_q;
  logic [24:0]      ye;
  logic [8:0]       qe_d, qe_q;
  hsv_sector_e      sec5_q;
  logic [ByteW-1:0] bc5_q, b05_q, bx;
  logic [12:0]      prod, rem;
  logic [9:0]       qx;
  logic [ByteW-1:0] red_d, green_d, blue_d, red_q, green_q, blue_q;

  always_comb begin
    n    = ({8'd0, data_i.vw} << 8) - {8'd0, data_i.vw} + 50'd515396075520;
    y_d  = n[47:36];
    ye   = 25'(y_d) * 25'd4369;
    qe_d = ye[24:16];
  end

  always_comb begin
    prod = 13'(qe_q) * 13'd15;
    rem  = 13'(y_q) - prod;
    qx   = (rem >= 13'd15) ? 10'(qe_q) + 10'd1 : 10'(qe_q);
    bx   = (qx > 10'd255) ? 8'd255 : qx[7:0];
    case (sec5_q)
      SEC_RY: begin
        red_d = bc5_q; green_d = bx;    blue_d = b05_q;
      end
      SEC_YG: begin
        red_d = bx;    green_d = bc5_q; blue_d = b05_q;
      end
      SEC_GC: begin
        red_d = b05_q; green_d = bc5_q; blue_d = bx;
      end
      SEC_CB: begin
        red_d = b05_q; green_d = bx;    blue_d = bc5_q;
      end
      SEC_BM: begin
        red_d = bx;    green_d = b05_q; blue_d = bc5_q;
      end
      default: begin
        red_d = bc5_q; green_d = b05_q; blue_d = bx;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
    end else if (en_i) begin
      vld5_q <= vld_i;
      vld6_q <= vld5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q     <= y_d;
      qe_q    <= qe_d;
      sec5_q  <= data_i.sec;
      bc5_q   <= data_i.bc;
      b05_q   <= data_i.b0;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign vld_o   = vld6_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  `ASSERT_STD(a_red_sector, (en_i && vld5_q && sec5_q == SEC_RY) |=> (red_q == $past(bc5_q)), "red not max in first sector")

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB pixel converter
//
//  channel  dir  tdata bits (low to high)
//  s_axis   in   hue[15:0] saturation[31:16] brightness[47:32]
//  m_axis   out  red[7:0] green[15:8] blue[23:16]
//
// Six register stages: a result is valid on m_axis once its item has passed through all six.
// One item per cycle while m_axis does not stall; the two multiply stages and the divide-by-15 fix-up set the depth.
// Reset clears the stage valid bits only.
// A stall on m_axis holds every stage; s_axis_tready follows the output slot.
module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // hue, saturation, brightness
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // red, green, blue
);

  logic             en;
  logic             vld_f, vld_m, vld_b;
  hsv_front_t       dat_f;
  hsv_mult_t        dat_m;
  logic [ByteW-1:0] red, green, blue;

  assign en            = !vld_b || m_axis_tready;
  assign s_axis_tready = en;

  hsv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .hue_i  (s_axis_tdata[15:0]),
    .sat_i  (s_axis_tdata[31:16]),
    .val_i  (s_axis_tdata[47:32]),
    .vld_o  (vld_f),
    .data_o (dat_f)
  );

  hsv_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_f),
    .data_i (dat_f),
    .vld_o  (vld_m),
    .data_o (dat_m)
  );

  hsv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_m),
    .data_i  (dat_m),
    .vld_o   (vld_b),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign m_axis_tvalid = vld_b;
  assign m_axis_tdata  = {blue, green, red};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the HSV to RGB converter with random stream flow control
`timescale 1ns / 1ps

module tb_top
  import hsv_pkg::*;
();

  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [HueW-1:0] sat;
    logic [HueW-1:0] bri;
    logic            known;
    rgb_t            rgb;
  } pix_row_t;

  localparam int unsigned     NumRows    = 20;
  localparam int unsigned     ItemsPhase = 400;
  localparam int unsigned     StallLimit = 2000;
  localparam int unsigned     TailCycles = 20;
  localparam longint unsigned ScaleDen   = 64'(HueSector) << 28;

  localparam rgb_t Black   = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
  localparam rgb_t White   = '{blue: 8'd255, green: 8'd255, red: 8'd255};
  localparam rgb_t Red     = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
  localparam rgb_t Yellow  = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
  localparam rgb_t Green   = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
  localparam rgb_t Cyan    = '{blue: 8'd255, green: 8'd255, red: 8'd0};
  localparam rgb_t Blue    = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
  localparam rgb_t Magenta = '{blue: 8'd255, green: 8'd0,   red: 8'd255};

  // hue, saturation, brightness, typed-in result or predicted
  localparam pix_row_t PixRows [NumRows] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, Black},
    '{16'sd0,      16'sd16384,  16'sd16384,  1'b1, Red},
    '{16'sd3840,   16'sd16384,  16'sd16384,  1'b1, Yellow},
    '{16'sd7680,   16'sd16384,  16'sd16384,  1'b1, Green},
    '{16'sd11520,  16'sd16384,  16'sd16384,  1'b1, Cyan},
    '{16'sd15360,  16'sd16384,  16'sd16384,  1'b1, Blue},
    '{16'sd19200,  16'sd16384,  16'sd16384,  1'b1, Magenta},
    '{16'sd23040,  16'sd16384,  16'sd16384,  1'b1, Red},
    '{-16'sd23040, 16'sd16384,  16'sd16384,  1'b1, Red},
    '{16'sh7fff,   16'sd16384,  16'sd16384,  1'b0, Black},
    '{16'sh8000,   16'sd16384,  16'sd16384,  1'b0, Black},
    '{-16'sd1,     16'sd16384,  16'sd16384,  1'b0, Black},
    '{16'sd1920,   16'sd16384,  16'sd16384,  1'b0, Black},
    '{16'sd0,      16'sh8000,   16'sd16384,  1'b1, White},
    '{16'sd0,      16'sh7fff,   16'sh7fff,   1'b1, Red},
    '{16'sd0,      16'sd16384,  16'sh8000,   1'b1, Black},
    '{16'sd0,      16'sd0,      16'sh7fff,   1'b1, White},
    '{16'sd5000,   16'sd8192,   16'sd8192,   1'b0, Black},
    '{-16'sd5000,  16'sd12000,  16'sd16000,  1'b0, Black},
    '{16'sd0,      16'sd16385,  16'sd16383,  1'b0, Black}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // hue, saturation, brightness
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;      // red, green, blue

  logic        pix_known = 1'b0;
  rgb_t        pix_ref = '0;
  rgb_t        rgb_due [$];
  int unsigned pixels_in = 0;
  int unsigned clamped_in = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  hsv_to_rgb_converter dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned clamp_q(logic signed [HueW-1:0] q);
    if (q < 0) return 0;
    if (q > $signed({1'b0, QOne})) return QOne;
    return longint'(q);
  endfunction

  function automatic logic [ByteW-1:0] chan_byte(longint unsigned t, longint unsigned m);
    longint unsigned q;
    q = ((t + m) * 255 + ScaleDen / 2) / ScaleDen;
    return (q > 255) ? 8'd255 : q[ByteW-1:0];
  endfunction

  function automatic rgb_t hsv_to_rgb(logic signed [HueW-1:0] hue,
                                      logic signed [HueW-1:0] sat,
                                      logic signed [HueW-1:0] bri);
    int              hw;
    int              fr;
    hsv_sector_e     sec;
    longint unsigned s, v, fn, c, x, m, r, g, b;
    rgb_t            px;
    hw  = (int'(hue) + int'(HueFull2)) % int'(HueFull1);
    sec = hsv_sector_e'(hw / int'(HueSector));
    fr  = hw % int'(HueSector);
    fn  = sec[0] ? longint'(int'(HueSector) - fr) : longint'(fr);
    s   = clamp_q(sat);
    v   = clamp_q(bri);
    c   = v * s * HueSector;
    x   = v * s * fn;
    m   = v * QOne * HueSector - c;
    case (sec)
      SEC_RY:  begin r = c; g = x; b = 0; end
      SEC_YG:  begin r = x; g = c; b = 0; end
      SEC_GC:  begin r = 0; g = c; b = x; end
      SEC_CB:  begin r = 0; g = x; b = c; end
      SEC_BM:  begin r = x; g = 0; b = c; end
      default: begin r = c; g = 0; b = x; end
    endcase
    px.red   = chan_byte(r, m);
    px.green = chan_byte(g, m);
    px.blue  = chan_byte(b, m);
    return px;
  endfunction

  function automatic logic [HueW-1:0] rand_hue();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 20) return 16'($urandom_range(6) * int'(HueSector) + $urandom_range(2) - 1);
    return 16'($urandom);
  endfunction

  function automatic logic [HueW-1:0] rand_q();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return 16'($urandom_range(QOne));
    if (k < 75) return k[0] ? 16'(QOne) : 16'd0;
    return 16'($urandom);
  endfunction

  task automatic send_pixel(logic [HueW-1:0] hue, logic [HueW-1:0] sat,
                            logic [HueW-1:0] bri, logic known, rgb_t rgb);
    int unsigned seen;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bri, sat, hue};
    pix_known     <= known;
    pix_ref       <= rgb;
    seen = pixels_in;
    do @(negedge clk_i); while (pixels_in == seen);
  endtask

  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (rgb_due.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    rgb_t due_px;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (pix_known) begin
          due_px = pix_ref;
        end else begin
          due_px = hsv_to_rgb(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32]);
        end
        rgb_due = {rgb_due, due_px};
        if (clamp_q(s_axis_tdata[31:16]) != longint'($signed(s_axis_tdata[31:16])) ||
            clamp_q(s_axis_tdata[47:32]) != longint'($signed(s_axis_tdata[47:32])))
          clamped_in <= clamped_in + 1;
        pixels_in <= pixels_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (rgb_due.size() == 0) begin
          $error("unexpected pixel %h", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = rgb_due.pop_front();
          if (got.red != want.red)
            $error("red: expected %0d, got %0d", want.red, got.red);
          if (got.green != want.green)
            $error("green: expected %0d, got %0d", want.green, got.green);
          if (got.blue != want.blue)
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
          if (got != want) mismatches <= mismatches + 1;
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $error("no handshake for %0d cycles, %0d pixels pending", StallLimit, rgb_due.size());
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle = 18;
    recv_idle = 63;
    foreach (PixRows[i])
      send_pixel(PixRows[i].hue, PixRows[i].sat, PixRows[i].bri,
                 PixRows[i].known, PixRows[i].rgb);
    drain_pixels();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 18 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 18 : 0;
      for (int n = 0; n < ItemsPhase; n++)
        send_pixel(rand_hue(), rand_q(), rand_q(), 1'b0, '0);
      drain_pixels();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (rgb_due.size() != 0) $error("%0d pixels never came out", rgb_due.size());
    $display("Converted %0d pixels, %0d from the directed table, %0d with clamped s or v,",
             pixels_in, NumRows, clamped_in);
    $display("under sender-heavy, receiver-heavy and back-to-back flow control.");
    if (mismatches == 0 && rgb_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
